// ===== design/md5_pkg.sv =====
// Shared constants and helper functions of the MD5 message hasher.
`timescale 1ns / 1ps
`default_nettype none

package md5_pkg;

   localparam int unsigned CHAIN_WORDS = 4;
   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned ROUNDS      = 64;

   // Fill levels of the block buffer, in bytes.
   localparam logic [6:0] FILL_FULL_M1 = 7'd63;
   localparam logic [6:0] FILL_LENGTH  = 7'd56;
   localparam logic [6:0] FILL_BLOCK   = 7'd64;

   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam logic [31:0] INIT_CHAIN [CHAIN_WORDS] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   localparam logic [31:0] ROUND_CONST [ROUNDS] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // Rotate amounts, indexed by {round group, round index bits 1:0}.
   localparam logic [4:0] ROT_AMOUNT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   // Message word used by a round.
   function automatic logic [3:0] word_index(input logic [5:0] round);
      logic [3:0] r;
      logic [3:0] idx;
      r = round[3:0];
      unique case (round[5:4])
         2'd0: idx = r;
         2'd1: idx = 4'(r * 4'd5 + 4'd1);
         2'd2: idx = 4'(r * 4'd3 + 4'd5);
         2'd3: idx = 4'(r * 4'd7);
         default: idx = r;
      endcase
      return idx;
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
      logic [63:0] t;
      t = {v, v} << s;
      return t[63:32];
   endfunction

endpackage

`default_nettype wire

// ===== design/md5_channels.sv =====
// Request and response channel interfaces of the MD5 message hasher.
`timescale 1ns / 1ps
`default_nettype none

interface md5_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] message_byte;
   logic       last_byte;

   modport source (output valid, output message_byte, output last_byte, input ready);
   modport sink   (input valid, input message_byte, input last_byte, output ready);
endinterface

interface md5_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word_a;
   logic [31:0] digest_word_b;
   logic [31:0] digest_word_c;
   logic [31:0] digest_word_d;

   modport source (output valid, output digest_word_a, output digest_word_b,
                   output digest_word_c, output digest_word_d, input ready);
   modport sink   (input valid, input digest_word_a, input digest_word_b,
                   input digest_word_c, input digest_word_d, output ready);
endinterface

`default_nettype wire

// ===== design/md5_message_hasher.sv =====
// Top level of the MD5 message hasher: byte intake, padding and the round sequencer.
//
// Usage: each request on req_if carries one message byte and a last-byte
// mark. Messages are at least one byte long. A response on rsp_if carries
// the 128-bit MD5 digest as four little-endian words, and comes only for a
// request whose last-byte mark is set.
// Throughput: in the idle state a byte is taken every cycle. Every 64th
// byte starts a compression (a load step, 64 rounds of the single shared
// round unit and a final step that adds into the chaining words), during
// which req_if.ready is low. After a last byte that leaves F bytes in the
// buffer, the sequencer writes the 0x80 mark, then the zero bytes (the
// zero run ends with a step that writes nothing), then the length, and
// runs a compression; F of 56 or more adds a second compression and more
// zero bytes. The digest and rsp_if.valid are registered when the final
// compression ends.
// Reset (synchronous, active high) empties the buffer count, clears the
// bit length, loads the standard initial chaining words and drops
// rsp_if.valid. The next message may start while a digest still waits in
// the output register; only the end of the next digest stalls until the
// receiver has taken the waiting one.
`timescale 1ns / 1ps
`default_nettype none

module md5_message_hasher (
   input  wire logic  clock,
   input  wire logic  reset,
   md5_req_if.sink    req_if,
   md5_rsp_if.source  rsp_if
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PAD,
      S_ZERO,
      S_LEN,
      S_PREP,
      S_ROUND,
      S_FINAL
   } state_type;

   // What the running compression is for, and so where the sequencer goes after it.
   typedef enum logic [1:0] {
      K_DATA,
      K_SPILL,
      K_LAST
   } kind_type;

   state_type   state_ff, state_in;
   kind_type    kind_ff, kind_in;
   logic [6:0]  fill_ff, fill_in;
   logic [63:0] bitlen_ff, bitlen_in;
   logic        last_ff, last_in;
   logic        spill_ff, spill_in;
   logic [5:0]  round_ff, round_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [31:0] ch_ff     [md5_pkg::CHAIN_WORDS];
   logic [31:0] ch_in     [md5_pkg::CHAIN_WORDS];
   logic [31:0] digest_ff [md5_pkg::CHAIN_WORDS];
   logic [31:0] digest_in [md5_pkg::CHAIN_WORDS];

   // Working variables of the compression and the precomputed K + W term.
   logic [31:0] wa_ff, wb_ff, wc_ff, wd_ff;
   logic [31:0] wa_in, wb_in, wc_in, wd_in;
   logic [31:0] kw_ff, kw_in;

   // Block buffer, held as sixteen little-endian words.
   logic [31:0] buf_ff [md5_pkg::BLOCK_WORDS];

   logic        accept;
   logic        digest_stall;
   logic [31:0] round_f;
   logic [31:0] round_sum;
   logic [31:0] round_b;
   logic [5:0]  kw_round;
   logic [4:0]  shift;

   assign accept       = req_if.valid && req_if.ready;
   assign digest_stall = rsp_valid_ff && !rsp_if.ready;

   assign req_if.ready         = (state_ff == S_IDLE);
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.digest_word_a = digest_ff[0];
   assign rsp_if.digest_word_b = digest_ff[1];
   assign rsp_if.digest_word_c = digest_ff[2];
   assign rsp_if.digest_word_d = digest_ff[3];

   // The shared round unit: one MD5 step per cycle.
   always_comb begin
      unique case (round_ff[5:4])
         2'd0: round_f = wd_ff ^ (wb_ff & (wc_ff ^ wd_ff));
         2'd1: round_f = wc_ff ^ (wd_ff & (wc_ff ^ wb_ff));
         2'd2: round_f = wb_ff ^ wc_ff ^ wd_ff;
         2'd3: round_f = wc_ff ^ (wb_ff | ~wd_ff);
         default: round_f = wb_ff ^ wc_ff ^ wd_ff;
      endcase
      shift     = md5_pkg::ROT_AMOUNT[{round_ff[5:4], round_ff[1:0]}];
      round_sum = wa_ff + round_f + kw_ff;
      round_b   = wb_ff + md5_pkg::rotl32(round_sum, shift);
      // K + W is registered before the round that uses it, so the round itself has one add less.
      kw_round  = (state_ff == S_PREP) ? 6'd0 : 6'(round_ff + 6'd1);
      kw_in     = md5_pkg::ROUND_CONST[kw_round] + buf_ff[md5_pkg::word_index(kw_round)];
   end

   // Sequencer next-state logic.
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      fill_in      = fill_ff;
      bitlen_in    = bitlen_ff;
      last_in      = last_ff;
      spill_in     = spill_ff;
      round_in     = round_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      wa_in        = wa_ff;
      wb_in        = wb_ff;
      wc_in        = wc_ff;
      wd_in        = wd_ff;
      for (int k = 0; k < md5_pkg::CHAIN_WORDS; k++) begin
         ch_in[k]     = ch_ff[k];
         digest_in[k] = digest_ff[k];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               fill_in   = 7'(fill_ff + 7'd1);
               bitlen_in = bitlen_ff + 64'd8;
               last_in   = req_if.last_byte;
               if (fill_ff == md5_pkg::FILL_FULL_M1) begin
                  kind_in  = K_DATA;
                  state_in = S_PREP;
               end else if (req_if.last_byte) begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            fill_in  = 7'(fill_ff + 7'd1);
            // The mark leaves no room for the length: a second block follows.
            spill_in = (fill_ff >= md5_pkg::FILL_LENGTH);
            state_in = S_ZERO;
         end
         S_ZERO: begin
            if (!spill_ff && fill_ff == md5_pkg::FILL_LENGTH) begin
               state_in = S_LEN;
            end else if (fill_ff == md5_pkg::FILL_BLOCK) begin
               kind_in  = K_SPILL;
               state_in = S_PREP;
            end else begin
               fill_in = 7'(fill_ff + 7'd1);
            end
         end
         S_LEN: begin
            kind_in  = K_LAST;
            state_in = S_PREP;
         end
         S_PREP: begin
            wa_in    = ch_ff[0];
            wb_in    = ch_ff[1];
            wc_in    = ch_ff[2];
            wd_in    = ch_ff[3];
            round_in = 6'd0;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            wa_in    = wd_ff;
            wb_in    = round_b;
            wc_in    = wb_ff;
            wd_in    = wc_ff;
            round_in = 6'(round_ff + 6'd1);
            if (round_ff == 6'(md5_pkg::ROUNDS - 1)) begin
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            unique case (kind_ff)
               K_DATA: begin
                  ch_in[0] = ch_ff[0] + wa_ff;
                  ch_in[1] = ch_ff[1] + wb_ff;
                  ch_in[2] = ch_ff[2] + wc_ff;
                  ch_in[3] = ch_ff[3] + wd_ff;
                  fill_in  = 7'd0;
                  state_in = last_ff ? S_PAD : S_IDLE;
               end
               K_SPILL: begin
                  ch_in[0] = ch_ff[0] + wa_ff;
                  ch_in[1] = ch_ff[1] + wb_ff;
                  ch_in[2] = ch_ff[2] + wc_ff;
                  ch_in[3] = ch_ff[3] + wd_ff;
                  fill_in  = 7'd0;
                  spill_in = 1'b0;
                  state_in = S_ZERO;
               end
               K_LAST: begin
                  // Hold the finished digest here until the output register is free.
                  if (!digest_stall) begin
                     digest_in[0] = ch_ff[0] + wa_ff;
                     digest_in[1] = ch_ff[1] + wb_ff;
                     digest_in[2] = ch_ff[2] + wc_ff;
                     digest_in[3] = ch_ff[3] + wd_ff;
                     rsp_valid_in = 1'b1;
                     for (int k = 0; k < md5_pkg::CHAIN_WORDS; k++) begin
                        ch_in[k] = md5_pkg::INIT_CHAIN[k];
                     end
                     fill_in   = 7'd0;
                     bitlen_in = 64'd0;
                     last_in   = 1'b0;
                     state_in  = S_IDLE;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kind_ff      <= K_DATA;
         fill_ff      <= 7'd0;
         bitlen_ff    <= 64'd0;
         last_ff      <= 1'b0;
         spill_ff     <= 1'b0;
         round_ff     <= 6'd0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < md5_pkg::CHAIN_WORDS; k++) begin
            ch_ff[k] <= md5_pkg::INIT_CHAIN[k];
         end
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         fill_ff      <= fill_in;
         bitlen_ff    <= bitlen_in;
         last_ff      <= last_in;
         spill_ff     <= spill_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < md5_pkg::CHAIN_WORDS; k++) begin
            ch_ff[k] <= ch_in[k];
         end
      end
      wa_ff <= wa_in;
      wb_ff <= wb_in;
      wc_ff <= wc_in;
      wd_ff <= wd_in;
      kw_ff <= kw_in;
      for (int k = 0; k < md5_pkg::CHAIN_WORDS; k++) begin
         digest_ff[k] <= digest_in[k];
      end
   end

   // Block buffer writes: message bytes, the pad mark, zero bytes and the length.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               buf_ff[fill_ff[5:2]][{fill_ff[1:0], 3'b000} +: 8] <= req_if.message_byte;
            end
         end
         S_PAD: begin
            buf_ff[fill_ff[5:2]][{fill_ff[1:0], 3'b000} +: 8] <= md5_pkg::PAD_MARK;
         end
         S_ZERO: begin
            if (fill_ff != md5_pkg::FILL_BLOCK &&
                !(!spill_ff && fill_ff == md5_pkg::FILL_LENGTH)) begin
               buf_ff[fill_ff[5:2]][{fill_ff[1:0], 3'b000} +: 8] <= 8'h00;
            end
         end
         S_LEN: begin
            buf_ff[md5_pkg::BLOCK_WORDS - 2] <= bitlen_ff[31:0];
            buf_ff[md5_pkg::BLOCK_WORDS - 1] <= bitlen_ff[63:32];
         end
         default: begin
         end
      endcase
   end

`ifndef SYNTHESIS
   a_prep_starts_round0: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PREP) |=> (state_ff == S_ROUND && round_ff == 6'd0))
      else $error("compression did not start at round zero");

   a_rsp_from_last_block: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(state_ff == S_FINAL && kind_ff == K_LAST))
      else $error("digest raised outside the final compression");

   a_reinit_after_digest: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINAL && kind_ff == K_LAST && !digest_stall) |=>
      (state_ff == S_IDLE && fill_ff == 7'd0 && bitlen_ff == 64'd0 &&
       ch_ff[0] == md5_pkg::INIT_CHAIN[0] && ch_ff[3] == md5_pkg::INIT_CHAIN[3]))
      else $error("hasher not reinitialized after a digest");

   a_zero_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ZERO && !spill_ff) |-> (fill_ff <= md5_pkg::FILL_LENGTH))
      else $error("zero padding ran past the length field");
`endif

endmodule

`default_nettype wire

// ===== tb/md5_digest_scoreboard.sv =====
// Scoreboard of the MD5 message hasher: predicts every digest and compares it with the response.
`timescale 1ns / 1ps

module md5_digest_scoreboard (
   input  logic        clock,
   input  logic        reset,
   md5_req_if          req_mon,
   md5_rsp_if          rsp_mon,
   output int unsigned mismatch_count,
   output int unsigned digests_pending
);

   typedef struct packed {
      logic [31:0] word_a;
      logic [31:0] word_b;
      logic [31:0] word_c;
      logic [31:0] word_d;
   } digest_type;

   localparam int unsigned REPORT_LIMIT = 10;
   localparam logic [7:0]  PAD_BYTE     = 8'h80;

   localparam logic [31:0] CHAIN_START [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   localparam logic [31:0] SINE_TABLE [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // Shift amounts, four per group of sixteen rounds.
   localparam int unsigned SHIFT_TABLE [16] = '{
      7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
   };

   logic [7:0]  msg_block [64];
   int unsigned block_fill;
   logic [63:0] message_bits;
   logic [31:0] chain [4];
   digest_type  expected_digests [$];

   function automatic logic [31:0] rotate_left(input logic [31:0] value,
                                               input int unsigned amount);
      return (value << amount) | (value >> (32 - amount));
   endfunction

   task automatic compress_block();
      logic [31:0] words [16];
      logic [31:0] a, b, c, d, mix, held;
      int unsigned pick, i;
      for (i = 0; i < 16; i++) begin
         words[i] = {msg_block[4*i+3], msg_block[4*i+2], msg_block[4*i+1], msg_block[4*i]};
      end
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (i = 0; i < 64; i++) begin
         case (i / 16)
            0: begin
               mix  = (b & c) | (~b & d);
               pick = i;
            end
            1: begin
               mix  = (b & d) | (c & ~d);
               pick = (5 * i + 1) % 16;
            end
            2: begin
               mix  = b ^ c ^ d;
               pick = (3 * i + 5) % 16;
            end
            default: begin
               mix  = c ^ (b | ~d);
               pick = (7 * i) % 16;
            end
         endcase
         held = d;
         d    = c;
         c    = b;
         b    = b + rotate_left(a + mix + SINE_TABLE[i] + words[pick],
                                SHIFT_TABLE[(i / 16) * 4 + i % 4]);
         a    = held;
      end
      chain[0] = chain[0] + a;
      chain[1] = chain[1] + b;
      chain[2] = chain[2] + c;
      chain[3] = chain[3] + d;
   endtask

   task automatic restart_message();
      block_fill   = 0;
      message_bits = '0;
      chain        = CHAIN_START;
   endtask

   // Takes one message byte; on the last one it pads, appends the length and
   // queues the resulting digest.
   task automatic absorb_byte(input logic [7:0] value, input logic is_last);
      digest_type  digest;
      int unsigned i;
      msg_block[block_fill] = value;
      block_fill++;
      message_bits += 64'd8;
      if (block_fill == 64) begin
         compress_block();
         block_fill = 0;
      end
      if (is_last) begin
         msg_block[block_fill] = PAD_BYTE;
         block_fill++;
         if (block_fill > 56) begin
            for (i = block_fill; i < 64; i++) msg_block[i] = 8'h00;
            compress_block();
            block_fill = 0;
         end
         for (i = block_fill; i < 56; i++) msg_block[i] = 8'h00;
         for (i = 0; i < 8; i++) msg_block[56 + i] = message_bits[8*i +: 8];
         compress_block();
         digest = '{chain[0], chain[1], chain[2], chain[3]};
         expected_digests.push_back(digest);
         restart_message();
      end
   endtask

   task automatic note_mismatch(input string what, input digest_type want,
                                input digest_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t: %s: expected %h %h %h %h, got %h %h %h %h", $realtime, what,
                  want.word_a, want.word_b, want.word_c, want.word_d,
                  got.word_a, got.word_b, got.word_c, got.word_d);
      end
   endtask

   initial begin
      for (int unsigned i = 0; i < 64; i++) msg_block[i] = 8'h00;
   end

   always @(posedge clock) begin
      digest_type seen, want;
      if (reset) begin
         restart_message();
         expected_digests.delete();
         mismatch_count = 0;
      end else begin
         // Responses first: a digest never leaves in the cycle its last byte arrives.
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = '{rsp_mon.digest_word_a, rsp_mon.digest_word_b,
                     rsp_mon.digest_word_c, rsp_mon.digest_word_d};
            if (expected_digests.size() == 0) begin
               note_mismatch("digest with none expected", '0, seen);
            end else begin
               want = expected_digests.pop_front();
               if (seen.word_a !== want.word_a || seen.word_b !== want.word_b ||
                   seen.word_c !== want.word_c || seen.word_d !== want.word_d) begin
                  note_mismatch("digest mismatch", want, seen);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            absorb_byte(req_mon.message_byte, req_mon.last_byte);
         end
      end
      digests_pending = expected_digests.size();
   end

endmodule

// ===== tb/tb_md5_message_hasher.sv =====
// Top of the MD5 message hasher testbench: clock, reset, byte stimulus and the verdict.
`timescale 1ns / 1ps

module tb_md5_message_hasher;

   // Byte content of one message.
   typedef enum int unsigned {
      PATTERN_RANDOM,
      PATTERN_ZEROS,
      PATTERN_ONES,
      PATTERN_RAMP
   } byte_pattern_type;

   localparam int unsigned RANDOM_BYTES    = 950;
   localparam int unsigned RANDOM_MESSAGES = 30;
   // The long receiver hold-off starts once this many messages went out.
   localparam int unsigned HOLD_AFTER      = 12;
   localparam int unsigned HOLD_CYCLES     = 3000;
   // Length of the quiet stretch after the final drain.
   localparam int unsigned DRAIN_CYCLES    = 300;

   // Message lengths around the block and padding boundaries: the mark fitting
   // just before the length field, the mark forcing a second block, and the
   // last byte filling a block exactly.
   localparam int unsigned BOUNDARY_LENGTHS [12] = '{
      55, 56, 57, 63, 64, 65, 119, 120, 121, 127, 128, 129
   };

   logic        clock;
   logic        reset;
   int unsigned mismatch_count;
   int unsigned digests_pending;
   int unsigned messages_sent;
   int unsigned bytes_sent;

   md5_req_if req_if ();
   md5_rsp_if rsp_if ();

   md5_message_hasher dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // The scoreboard sits beside the block and watches both channels; this
   // module only makes stimulus and reads the failure count at the end.
   md5_digest_scoreboard scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_if),
      .rsp_mon         (rsp_if),
      .mismatch_count  (mismatch_count),
      .digests_pending (digests_pending)
   );

   initial clock = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Idle gaps: mostly none, often a few cycles, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Most messages are short so that digests come often; a share sits on the
   // padding boundaries and a few span several blocks.
   function automatic int unsigned pick_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 12);
      if (roll < 88) return $urandom_range(13, 54);
      if (roll < 97) return BOUNDARY_LENGTHS[$urandom_range(0, 11)];
      return $urandom_range(130, 200);
   endfunction

   function automatic byte_pattern_type pick_pattern();
      case ($urandom_range(0, 9))
         0:       return PATTERN_ZEROS;
         1:       return PATTERN_ONES;
         2:       return PATTERN_RAMP;
         default: return PATTERN_RANDOM;
      endcase
   endfunction

   // Offers one request and returns at the falling edge after it was taken.
   // Valid stays high straight into the next request when there is no gap, so
   // it is never lowered and raised at the same edge.
   task automatic send_byte(input logic [7:0] value, input logic is_last,
                            input int unsigned gap);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.message_byte <= value;
      req_if.last_byte    <= is_last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Sends a whole message; a steady message goes out without any sender gaps.
   task automatic send_message(input int unsigned length, input byte_pattern_type pattern,
                               input bit steady);
      logic [7:0]  value;
      int unsigned k;
      for (k = 0; k < length; k++) begin
         case (pattern)
            PATTERN_ZEROS: value = 8'h00;
            PATTERN_ONES:  value = 8'hff;
            PATTERN_RAMP:  value = k[7:0];
            default:       value = 8'($urandom_range(0, 255));
         endcase
         send_byte(value, k == length - 1, steady ? 0 : pick_gap());
         bytes_sent++;
      end
      messages_sent++;
   endtask

   // Lowers valid and waits until every queued digest has come back.
   task automatic wait_for_digests();
      req_if.valid <= 1'b0;
      while (digests_pending != 0) @(negedge clock);
   endtask

   // Watchdog: a run that hangs on a missing digest or a stuck handshake ends here.
   initial begin
      #4_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Receiver side: ready goes low for random stalls between runs of random
   // length, some of them long, so stalls land on every phase of the block's
   // work. Once, early in the random part, it holds off for a long stretch
   // while the sender keeps offering bytes; the waiting digest then blocks the
   // next one, and the block stops taking bytes.
   initial begin : response_side
      int unsigned stall, run;
      bit          held_once;
      held_once = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held_once && messages_sent >= HOLD_AFTER) begin
            held_once = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         stall = pick_gap();
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         run = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 12);
         repeat (run) @(negedge clock);
      end
   end

   // Sender side and verdict.
   initial begin
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.message_byte = 8'h00;
      req_if.last_byte    = 1'b0;
      rsp_if.ready        = 1'b0;
      messages_sent       = 0;
      bytes_sent          = 0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Directed messages: one-byte messages at both byte extremes, a short
      // ramp, a message whose pad mark no longer leaves room for the length
      // field (the padding spills into a second block), and one whose last
      // byte fills a block exactly so that padding starts a fresh block.
      send_message(1, PATTERN_ZEROS, 1'b1);
      send_message(1, PATTERN_ONES, 1'b1);
      send_message(3, PATTERN_RAMP, 1'b0);
      send_message(56, PATTERN_ONES, 1'b1);
      send_message(64, PATTERN_RANDOM, 1'b0);

      // The sender pauses until the block has returned every digest.
      wait_for_digests();

      // Random messages: lengths biased toward short ones and the padding
      // boundaries, content mostly random, a quarter sent with no gaps.
      while (bytes_sent < RANDOM_BYTES || messages_sent < RANDOM_MESSAGES) begin
         send_message(pick_length(), pick_pattern(), $urandom_range(0, 3) == 0);
      end

      // Drain: every expected digest back, then a quiet stretch in which a
      // stray extra response would still be caught.
      wait_for_digests();
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && digests_pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== md5_message_hasher.f =====
design/md5_pkg.sv
design/md5_channels.sv
design/md5_message_hasher.sv
tb/md5_digest_scoreboard.sv
tb/tb_md5_message_hasher.sv
